### rtl/core/vector_length_direction_angles_macros.svh
// Assertion macros for the vector length and direction angle block
`ifndef VECTOR_LENGTH_DIRECTION_ANGLES_MACROS_SVH
`define VECTOR_LENGTH_DIRECTION_ANGLES_MACROS_SVH

// check a consequence in the same cycle
`define VLDA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vlda same-cycle check failed");

// check a consequence in the next cycle
`define VLDA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vlda next-cycle check failed");

`endif

### rtl/core/vlda_pkg.sv
// Package: widths, constants, types and the arctangent table of the vector block
`timescale 1ns / 1ps
`default_nettype none

package vlda_pkg;

   localparam int COORD_W    = 24;
   localparam int DIFF_W     = 25;
   localparam int MAG_W      = 24;
   localparam int SQ_W       = 48;
   localparam int SUM_W      = 50;
   localparam int LEN_W      = 25;
   localparam int AIN_W      = 19;
   localparam int AOUT_W     = 18;
   localparam int STAT_W     = 2;
   localparam int AUX_W      = 32;
   localparam int RAD_W      = 62;
   localparam int ROOT_W     = 31;
   localparam int REM_W      = 34;
   localparam int SQRT_STEPS = 31;
   localparam int LANES      = 4;
   localparam int AXES       = 3;
   localparam int CW         = 36;
   localparam int ATAN_W     = 30;
   localparam int PROD_W     = 58;

   localparam int CORDIC_STAGES_DEF = 18;

   localparam logic [33:0]       PI_Q30      = 34'd3373259426;
   localparam logic [33:0]       HALF_PI_Q30 = 34'd1686629713;
   localparam logic [33:0]       TWO_PI_Q30  = 34'd6746518852;
   localparam logic [AOUT_W-1:0] PI_Q16      = 18'd205887;
   localparam logic [CW-1:0]     GAIN_Q30    = 36'd652032874;

   localparam logic signed [29:0] COORD_MAX = 30'sd8388607;
   localparam logic signed [29:0] COORD_MIN = -30'sd8388608;

   localparam logic ACT_POLAR = 1'b0;
   localparam logic ACT_POINT = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

   typedef struct packed {
      logic                           action;
      logic [AXES-1:0][COORD_W-1:0]   start;
      logic [AXES-1:0][COORD_W-1:0]   end_pt;
      logic [LEN_W-1:0]               len;
      logic [AXES-1:0][AIN_W-1:0]     ang;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]               length_out;
      logic [AXES-1:0][AOUT_W-1:0]    angle;
      logic [AXES-1:0][COORD_W-1:0]   result;
      logic [STAT_W-1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic                           action;
      logic                           zero;
      logic [AXES-1:0]                dneg;
      logic [AXES-1:0]                aneg;
      logic [AXES-1:0][COORD_W-1:0]   start;
      logic [LEN_W-1:0]               len;
      logic [AXES-1:0][AUX_W-1:0]     aux;
      logic [LEN_W-1:0]               len_out;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_lane_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_lane_type;

   function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 30'd843314856;
         5'd1:    v = 30'd497837829;
         5'd2:    v = 30'd263043836;
         5'd3:    v = 30'd133525158;
         5'd4:    v = 30'd67021686;
         5'd5:    v = 30'd33543515;
         5'd6:    v = 30'd16775850;
         5'd7:    v = 30'd8388437;
         5'd8:    v = 30'd4194282;
         5'd9:    v = 30'd2097149;
         5'd10:   v = 30'd1048575;
         5'd11:   v = 30'd524287;
         5'd12:   v = 30'd262143;
         5'd13:   v = 30'd131071;
         5'd14:   v = 30'd65535;
         5'd15:   v = 30'd32767;
         5'd16:   v = 30'd16383;
         5'd17:   v = 30'd8191;
         5'd18:   v = 30'd4095;
         5'd19:   v = 30'd2047;
         5'd20:   v = 30'd1023;
         5'd21:   v = 30'd511;
         5'd22:   v = 30'd255;
         5'd23:   v = 30'd127;
         5'd24:   v = 30'd63;
         5'd25:   v = 30'd31;
         5'd26:   v = 30'd15;
         5'd27:   v = 30'd8;
         5'd28:   v = 30'd4;
         5'd29:   v = 30'd2;
         5'd30:   v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/core/vlda_req_if.sv
// Interface: request channel carrying one input word
`timescale 1ns / 1ps
`default_nettype none

interface vlda_req_if import vlda_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] start_z;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic signed [COORD_W-1:0] end_z;
   logic [LEN_W-1:0]          length_in;
   logic [AIN_W-1:0]          angle_x_in;
   logic [AIN_W-1:0]          angle_y_in;
   logic [AIN_W-1:0]          angle_z_in;

   modport source (output valid, action, start_x, start_y, start_z, end_x, end_y, end_z,
                   length_in, angle_x_in, angle_y_in, angle_z_in, input ready);
   modport sink   (input valid, action, start_x, start_y, start_z, end_x, end_y, end_z,
                   length_in, angle_x_in, angle_y_in, angle_z_in, output ready);
endinterface

`default_nettype wire

### rtl/core/vlda_rsp_if.sv
// Interface: response channel carrying one result word
`timescale 1ns / 1ps
`default_nettype none

interface vlda_rsp_if import vlda_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [LEN_W-1:0]          length_out;
   logic [AOUT_W-1:0]         angle_x_out;
   logic [AOUT_W-1:0]         angle_y_out;
   logic [AOUT_W-1:0]         angle_z_out;
   logic signed [COORD_W-1:0] result_x;
   logic signed [COORD_W-1:0] result_y;
   logic signed [COORD_W-1:0] result_z;
   logic [STAT_W-1:0]         status;

   modport source (output valid, length_out, angle_x_out, angle_y_out, angle_z_out,
                   result_x, result_y, result_z, status, input ready);
   modport sink   (input valid, length_out, angle_x_out, angle_y_out, angle_z_out,
                   result_x, result_y, result_z, status, output ready);
   modport mon    (input valid, ready, length_out, angle_x_out, angle_y_out, angle_z_out,
                   result_x, result_y, result_z, status);
endinterface

`default_nettype wire

### rtl/core/vector_length_direction_angles.sv
// Top level: 3D vector length and direction angles, and end point from length and angles
// Takes one word per clock while the pipeline advances and gives one result word per
// word, in order. The pipeline is built from four front stages, a row of 31 square-root
// cells that each settle one root bit for four lanes at once, a row of CORDIC_STAGES
// cells (18 by default) that each do one micro-rotation for three lanes, two finishing
// stages and the output register. The pipeline advances whenever the output register
// is free or being drained, or its last stage is empty, so the block keeps taking words
// while a result waits until a word reaches the last stage.
`timescale 1ns / 1ps
`default_nettype none

module vector_length_direction_angles import vlda_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   vlda_req_if.sink        req_ch,
   vlda_rsp_if.source      rsp_ch
);

   logic                             en;
   req_type                          req_word;

   logic                             front_valid;
   side_type                         front_side;
   sqrt_lane_type [LANES-1:0]        front_lanes;

   logic                             sqv_in [SQRT_STEPS];
   side_type                         sqs_in [SQRT_STEPS];
   sqrt_lane_type [LANES-1:0]        sql_in [SQRT_STEPS];
   logic                             sqv_ff [SQRT_STEPS];
   side_type                         sqs_ff [SQRT_STEPS];
   sqrt_lane_type [LANES-1:0]        sql    [SQRT_STEPS];

   side_type                         setup_side;
   cordic_lane_type [AXES-1:0]       setup_lanes;

   logic                             cdv_in [CORDIC_STAGES];
   side_type                         cds_in [CORDIC_STAGES];
   cordic_lane_type [AXES-1:0]       cdl_in [CORDIC_STAGES];
   logic                             cdv_ff [CORDIC_STAGES];
   side_type                         cds_ff [CORDIC_STAGES];
   cordic_lane_type [AXES-1:0]       cdl    [CORDIC_STAGES];

   logic                             back_valid;
   rsp_type                          back_rsp;
   logic                             rsp_valid_ff;
   rsp_type                          rsp_word_ff;

   assign en           = rsp_ch.ready || !rsp_valid_ff || !back_valid;
   assign req_ch.ready = en;

   assign req_word.action = req_ch.action;
   assign req_word.start  = {req_ch.start_z, req_ch.start_y, req_ch.start_x};
   assign req_word.end_pt = {req_ch.end_z, req_ch.end_y, req_ch.end_x};
   assign req_word.len    = req_ch.length_in;
   assign req_word.ang    = {req_ch.angle_z_in, req_ch.angle_y_in, req_ch.angle_x_in};

   vlda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .req       (req_word),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_lanes (front_lanes)
   );

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      if (k == 0) begin : g_first
         assign sqv_in[k] = front_valid;
         assign sqs_in[k] = front_side;
         assign sql_in[k] = front_lanes;
      end else begin : g_next
         assign sqv_in[k] = sqv_ff[k-1];
         assign sqs_in[k] = sqs_ff[k-1];
         assign sql_in[k] = sql[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[k] <= 1'b0;
         end else if (en) begin
            sqv_ff[k] <= sqv_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sqs_ff[k] <= sqs_in[k];
         end
      end

      for (genvar j = 0; j < LANES; j++) begin : g_lane
         vlda_sqrt_cell u_cell (
            .clock    (clock),
            .en       (en),
            .lane_in  (sql_in[k][j]),
            .lane_out (sql[k][j])
         );
      end
   end

   always_comb begin
      setup_side         = sqs_ff[SQRT_STEPS-1];
      setup_side.len_out = sql[SQRT_STEPS-1][0].root[LEN_W-1:0];
      for (int j = 0; j < AXES; j++) begin
         if (setup_side.action == ACT_POINT) begin
            setup_lanes[j].x = GAIN_Q30;
            setup_lanes[j].y = '0;
            setup_lanes[j].z = {{(CW-AUX_W){1'b0}}, setup_side.aux[j]};
         end else begin
            setup_lanes[j].x = {{(CW-MAG_W-6){1'b0}}, setup_side.aux[j][MAG_W-1:0], 6'b0};
            setup_lanes[j].y = {{(CW-ROOT_W){1'b0}}, sql[SQRT_STEPS-1][j+1].root};
            setup_lanes[j].z = '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      if (i == 0) begin : g_first
         assign cdv_in[i] = sqv_ff[SQRT_STEPS-1];
         assign cds_in[i] = setup_side;
         assign cdl_in[i] = setup_lanes;
      end else begin : g_next
         assign cdv_in[i] = cdv_ff[i-1];
         assign cds_in[i] = cds_ff[i-1];
         assign cdl_in[i] = cdl[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cdv_ff[i] <= 1'b0;
         end else if (en) begin
            cdv_ff[i] <= cdv_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cds_ff[i] <= cds_in[i];
         end
      end

      for (genvar j = 0; j < AXES; j++) begin : g_lane
         vlda_cordic_cell #(
            .SHIFT (i)
         ) u_cell (
            .clock    (clock),
            .en       (en),
            .mode     (cds_in[i].action),
            .lane_in  (cdl_in[i][j]),
            .lane_out (cdl[i][j])
         );
      end
   end

   vlda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cdv_ff[CORDIC_STAGES-1]),
      .in_side   (cds_ff[CORDIC_STAGES-1]),
      .in_lanes  (cdl[CORDIC_STAGES-1]),
      .out_valid (back_valid),
      .out_rsp   (back_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ch.ready || !rsp_valid_ff) begin
         rsp_valid_ff <= back_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ch.ready || !rsp_valid_ff) begin
         rsp_word_ff <= back_rsp;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.length_out  = rsp_word_ff.length_out;
   assign rsp_ch.angle_x_out = rsp_word_ff.angle[0];
   assign rsp_ch.angle_y_out = rsp_word_ff.angle[1];
   assign rsp_ch.angle_z_out = rsp_word_ff.angle[2];
   assign rsp_ch.result_x    = rsp_word_ff.result[0];
   assign rsp_ch.result_y    = rsp_word_ff.result[1];
   assign rsp_ch.result_z    = rsp_word_ff.result[2];
   assign rsp_ch.status      = rsp_word_ff.status;

endmodule

`default_nettype wire

### rtl/core/vlda_front.sv
// Front stages: differences, angle reduction, squares, sum and square-root operands
`timescale 1ns / 1ps
`default_nettype none

module vlda_front import vlda_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  req_type                         req,
   output logic                            out_valid,
   output side_type                        out_side,
   output sqrt_lane_type [LANES-1:0]       out_lanes
);

   function automatic logic [AUX_W:0] reduce_angle(input logic [AIN_W-1:0] ang);
      logic [33:0] a0;
      logic [33:0] a1;
      logic [33:0] a2;
      logic        neg;
      a0  = {1'b0, ang, 14'b0};
      a1  = (a0 >= TWO_PI_Q30) ? a0 - TWO_PI_Q30 : a0;
      a2  = (a1 > PI_Q30) ? TWO_PI_Q30 - a1 : a1;
      neg = 1'b0;
      if (a2 > HALF_PI_Q30) begin
         a2  = PI_Q30 - a2;
         neg = 1'b1;
      end
      return {neg, a2[AUX_W-1:0]};
   endfunction

   logic                           a_valid_ff;
   side_type                       a_side_ff, a_side_in;
   logic [AXES-1:0][DIFF_W-1:0]    a_diff_ff, a_diff_in;

   logic                           b_valid_ff;
   side_type                       b_side_ff, b_side_in;
   logic [AXES-1:0][SQ_W-1:0]      b_sq_ff, b_sq_in;

   logic                           c_valid_ff;
   side_type                       c_side_ff;
   logic [AXES-1:0][SQ_W-1:0]      c_sq_ff;
   logic [SUM_W-1:0]               c_sum_ff, c_sum_in;

   logic                           d_valid_ff;
   side_type                       d_side_ff, d_side_in;
   sqrt_lane_type [LANES-1:0]      d_lanes_ff, d_lanes_in;

   logic [DIFF_W-1:0]              neg_diff;
   logic [MAG_W-1:0]               mag;
   logic [SUM_W-1:0]               rest;

   always_comb begin
      a_side_in        = '0;
      a_side_in.action = req.action;
      a_side_in.start  = req.start;
      a_side_in.len    = req.len;
      for (int j = 0; j < AXES; j++) begin
         a_diff_in[j] = {req.end_pt[j][COORD_W-1], req.end_pt[j]}
                      - {req.start[j][COORD_W-1], req.start[j]};
         {a_side_in.aneg[j], a_side_in.aux[j]} = reduce_angle(req.ang[j]);
      end
   end

   always_comb begin
      b_side_in = a_side_ff;
      neg_diff  = '0;
      mag       = '0;
      for (int j = 0; j < AXES; j++) begin
         neg_diff          = -a_diff_ff[j];
         mag               = a_diff_ff[j][DIFF_W-1] ? neg_diff[MAG_W-1:0]
                                                    : a_diff_ff[j][MAG_W-1:0];
         b_sq_in[j]        = {{(SQ_W-MAG_W){1'b0}}, mag} * {{(SQ_W-MAG_W){1'b0}}, mag};
         b_side_in.dneg[j] = a_diff_ff[j][DIFF_W-1];
         if (a_side_ff.action == ACT_POLAR) begin
            b_side_in.aux[j] = {{(AUX_W-MAG_W){1'b0}}, mag};
         end
      end
   end

   assign c_sum_in = SUM_W'(b_sq_ff[0]) + SUM_W'(b_sq_ff[1]) + SUM_W'(b_sq_ff[2]);

   always_comb begin
      d_side_in            = c_side_ff;
      d_side_in.zero       = (c_sum_ff == '0);
      d_lanes_in           = '0;
      d_lanes_in[0].rad    = {{(RAD_W-SUM_W){1'b0}}, c_sum_ff};
      rest                 = '0;
      for (int j = 0; j < AXES; j++) begin
         rest                = c_sum_ff - SUM_W'(c_sq_ff[j]);
         d_lanes_in[j+1].rad = {rest, {(RAD_W-SUM_W){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff  <= a_side_in;
         a_diff_ff  <= a_diff_in;
         b_side_ff  <= b_side_in;
         b_sq_ff    <= b_sq_in;
         c_side_ff  <= b_side_ff;
         c_sq_ff    <= b_sq_ff;
         c_sum_ff   <= c_sum_in;
         d_side_ff  <= d_side_in;
         d_lanes_ff <= d_lanes_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_side  = d_side_ff;
   assign out_lanes = d_lanes_ff;

endmodule

`default_nettype wire

### rtl/core/vlda_sqrt_cell.sv
// Square-root cell: one restoring step, one root bit per cycle while enabled
`timescale 1ns / 1ps
`default_nettype none

module vlda_sqrt_cell import vlda_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  sqrt_lane_type lane_in,
   output sqrt_lane_type lane_out
);

   logic [REM_W+1:0]  r2;
   logic [REM_W+1:0]  trial;
   sqrt_lane_type     lane_in_nxt;
   sqrt_lane_type     lane_ff;

   always_comb begin
      r2              = {lane_in.rem, lane_in.rad[RAD_W-1 -: 2]};
      trial           = {{(REM_W+2-ROOT_W-2){1'b0}}, lane_in.root, 2'b01};
      lane_in_nxt.rad = {lane_in.rad[RAD_W-3:0], 2'b00};
      if (r2 >= trial) begin
         lane_in_nxt.rem  = REM_W'(r2 - trial);
         lane_in_nxt.root = {lane_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         lane_in_nxt.rem  = REM_W'(r2);
         lane_in_nxt.root = {lane_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_nxt;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

### rtl/core/vlda_cordic_cell.sv
// CORDIC cell: one micro-rotation, vectoring or rotating as the word asks
`timescale 1ns / 1ps
`default_nettype none

module vlda_cordic_cell import vlda_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic            clock,
   input  logic            en,
   input  logic            mode,
   input  cordic_lane_type lane_in,
   output cordic_lane_type lane_out
);

   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [CW-1:0] at;
   logic                 rot;
   cordic_lane_type      lane_in_nxt;
   cordic_lane_type      lane_ff;

   always_comb begin
      xs  = $signed(lane_in.x) >>> SHIFT;
      ys  = $signed(lane_in.y) >>> SHIFT;
      at  = $signed({{(CW-ATAN_W){1'b0}}, atan_q30(5'(SHIFT))});
      rot = (mode == ACT_POINT) ? !lane_in.z[CW-1] : lane_in.y[CW-1];
      if (rot) begin
         lane_in_nxt.x = lane_in.x - ys;
         lane_in_nxt.y = lane_in.y + xs;
         lane_in_nxt.z = lane_in.z - at;
      end else begin
         lane_in_nxt.x = lane_in.x + ys;
         lane_in_nxt.y = lane_in.y - xs;
         lane_in_nxt.z = lane_in.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_nxt;
      end
   end

   assign lane_out = lane_ff;

endmodule

`default_nettype wire

### rtl/core/vlda_back.sv
// Back stages: angle rounding and mirroring, end-point product, add and clamp
`timescale 1ns / 1ps
`default_nettype none

module vlda_back import vlda_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  side_type                    in_side,
   input  cordic_lane_type [AXES-1:0]  in_lanes,
   output logic                        out_valid,
   output rsp_type                     out_rsp
);

   logic                             f_valid_ff;
   side_type                         f_side_ff;
   logic [AXES-1:0][AOUT_W-1:0]      f_ang_ff, f_ang_in;
   logic signed [PROD_W-1:0]         f_prod_ff [AXES];
   logic signed [PROD_W-1:0]         f_prod_in [AXES];

   logic                             g_valid_ff;
   rsp_type                          g_rsp_ff, g_rsp_in;

   logic [CW-1:0]                    zc;
   logic [CW-1:0]                    rnd;
   logic [AOUT_W-1:0]                ang;
   logic signed [CW-1:0]             cosx;
   logic signed [PROD_W:0]           tsum;
   logic signed [29:0]               v;
   logic                             sat;

   always_comb begin
      zc   = '0;
      rnd  = '0;
      ang  = '0;
      cosx = '0;
      for (int j = 0; j < AXES; j++) begin
         zc   = in_lanes[j].z[CW-1] ? '0 : in_lanes[j].z;
         rnd  = (zc + CW'(8192)) >> 14;
         ang  = (rnd > CW'(PI_Q16)) ? PI_Q16 : rnd[AOUT_W-1:0];
         if (in_side.dneg[j]) begin
            ang = PI_Q16 - ang;
         end
         if (in_side.action == ACT_POINT || in_side.zero) begin
            ang = '0;
         end
         f_ang_in[j]  = ang;
         cosx         = in_side.aneg[j] ? -in_lanes[j].x : in_lanes[j].x;
         f_prod_in[j] = $signed({1'b0, in_side.len}) * $signed(cosx[31:0]);
      end
   end

   always_comb begin
      g_rsp_in = '0;
      sat      = 1'b0;
      v        = '0;
      tsum     = '0;
      if (f_side_ff.action == ACT_POLAR) begin
         if (f_side_ff.zero) begin
            g_rsp_in.status = STAT_ZERO;
         end else begin
            g_rsp_in.length_out = f_side_ff.len_out;
            g_rsp_in.angle      = f_ang_ff;
            g_rsp_in.status     = STAT_OK;
         end
      end else begin
         for (int j = 0; j < AXES; j++) begin
            tsum = $signed({f_prod_ff[j][PROD_W-1], f_prod_ff[j]})
                 + $signed((PROD_W+1)'(536870912));
            v    = $signed({{(30-COORD_W){f_side_ff.start[j][COORD_W-1]}},
                             f_side_ff.start[j]})
                 + $signed({tsum[PROD_W], tsum[PROD_W:30]});
            if (v > COORD_MAX) begin
               v   = COORD_MAX;
               sat = 1'b1;
            end
            if (v < COORD_MIN) begin
               v   = COORD_MIN;
               sat = 1'b1;
            end
            g_rsp_in.result[j] = v[COORD_W-1:0];
         end
         g_rsp_in.status = sat ? STAT_SAT : STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= in_valid;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_side_ff <= in_side;
         f_ang_ff  <= f_ang_in;
         for (int j = 0; j < AXES; j++) begin
            f_prod_ff[j] <= f_prod_in[j];
         end
         g_rsp_ff  <= g_rsp_in;
      end
   end

   assign out_valid = g_valid_ff;
   assign out_rsp   = g_rsp_ff;

endmodule

`default_nettype wire

### rtl/core/vlda_checker.sv
// Checker: port-level assertions on the result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "vector_length_direction_angles_macros.svh"

module vlda_checker import vlda_pkg::*; (
   input logic         clock,
   input logic         reset,
   vlda_rsp_if.source  rsp_ch
);

   `VLDA_ASSERT_NEXT(a_rsp_hold, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid)
   `VLDA_ASSERT_SAME(a_status_code, rsp_ch.valid, rsp_ch.status != 2'd3)
   `VLDA_ASSERT_SAME(a_zero_clear, rsp_ch.valid && rsp_ch.status == STAT_ZERO, rsp_ch.length_out == '0 && rsp_ch.angle_x_out == '0 && rsp_ch.angle_y_out == '0 && rsp_ch.angle_z_out == '0 && rsp_ch.result_x == '0 && rsp_ch.result_y == '0 && rsp_ch.result_z == '0)
   `VLDA_ASSERT_SAME(a_sat_point, rsp_ch.valid && rsp_ch.status == STAT_SAT, rsp_ch.length_out == '0 && rsp_ch.angle_x_out == '0 && rsp_ch.angle_y_out == '0 && rsp_ch.angle_z_out == '0)
   `VLDA_ASSERT_SAME(a_length_ok, rsp_ch.valid && rsp_ch.length_out != '0, rsp_ch.status == STAT_OK)

endmodule

bind vector_length_direction_angles vlda_checker u_vlda_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);

`default_nettype wire
